// ----- rtl/ofds_pkg.sv -----
// Shared types and constants for the optical flow frame decoder.
`default_nettype none
package ofds_pkg;

  // Frame markers
  localparam logic [7:0] FRAME_HEADER = 8'hFE;
  localparam logic [7:0] FRAME_ID     = 8'h04;
  localparam logic [7:0] FRAME_FOOTER = 8'hAA;
  localparam int unsigned FRAME_LEN   = 9;
  localparam int unsigned FRESH_W     = 4;

  // Register map
  localparam int unsigned CFG_AW = 3;
  localparam logic REG_SCALE_GAIN = 1'b0;
  localparam logic REG_RATE_GAIN  = 1'b1;
  localparam logic [15:0] SCALE_GAIN_RESET = 16'd8215;
  localparam logic [15:0] RATE_GAIN_RESET  = 16'd669;

  // Shared multiplier widths
  localparam int unsigned MUL_AW = 34;
  localparam int unsigned MUL_BW = 17;
  localparam int unsigned PROD_W = MUL_AW + MUL_BW;

  typedef struct packed {
    logic        [7:0]  rx_byte;
    logic signed [15:0] roll_vel;
    logic signed [15:0] pitch_vel;
    logic        [15:0] height;
  } in_t;

  typedef struct packed {
    logic signed [31:0] x_flow;
    logic signed [31:0] y_flow;
    logic        [7:0]  quality;
  } out_t;

  // Frame content seen by the sequencer
  typedef struct packed {
    logic               hit;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic        [7:0]  quality;
  } frame_t;

  // Gains from the register block
  typedef struct packed {
    logic [15:0] scale_gain;
    logic [15:0] rate_gain;
  } gains_t;

endpackage
`default_nettype wire

// ----- rtl/ofds_regs.sv -----
// APB register block holding the scale and rate gains.
`default_nettype none
module ofds_regs
  import ofds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready,
  output gains_t                 gains
);

  logic [15:0] scale_gain_r;
  logic [15:0] rate_gain_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;

  // Write gains on the access phase of a write request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_gain_r <= SCALE_GAIN_RESET;
      rate_gain_r  <= RATE_GAIN_RESET;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        REG_SCALE_GAIN: scale_gain_r <= cfg_pwdata[15:0];
        REG_RATE_GAIN:  rate_gain_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_paddr[2])
      REG_SCALE_GAIN: cfg_prdata = {16'd0, scale_gain_r};
      REG_RATE_GAIN:  cfg_prdata = {16'd0, rate_gain_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  assign gains.scale_gain = scale_gain_r;
  assign gains.rate_gain  = rate_gain_r;

endmodule
`default_nettype wire

// ----- rtl/ofds_frame.sv -----
// Byte window, fresh byte count and frame match.
`default_nettype none
module ofds_frame
  import ofds_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       shift_en,
  input  wire logic [7:0] rx_byte,
  output frame_t          frame
);

  logic [7:0]         win_r   [FRAME_LEN];
  logic [7:0]         win_nxt [FRAME_LEN];
  logic [FRESH_W-1:0] fresh_r;
  logic [FRESH_W-1:0] fresh_inc;
  logic [FRESH_W-1:0] fresh_nxt;
  logic               hit;

  // Slide the window by one byte
  always_comb begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[FRAME_LEN-1] = rx_byte;
  end

  // Count fresh bytes, saturating at a full frame
  assign fresh_inc = (fresh_r < FRESH_W'(FRAME_LEN)) ? fresh_r + 1'b1 : fresh_r;

  assign hit = (fresh_inc == FRESH_W'(FRAME_LEN)) &&
               (win_nxt[0] == FRAME_HEADER) &&
               (win_nxt[1] == FRAME_ID) &&
               (win_nxt[FRAME_LEN-1] == FRAME_FOOTER);

  // Restart the count after a match
  assign fresh_nxt = hit ? '0 : fresh_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= '0;
      for (int i = 0; i < FRAME_LEN; i++) begin
        win_r[i] <= 8'd0;
      end
    end else if (shift_en) begin
      fresh_r <= fresh_nxt;
      for (int i = 0; i < FRAME_LEN; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // Match uses the incoming byte; payload comes from the settled window
  assign frame.hit     = hit;
  assign frame.mx      = {win_r[3], win_r[2]};
  assign frame.my      = {win_r[5], win_r[4]};
  assign frame.quality = win_r[7];

endmodule
`default_nettype wire

// ----- rtl/ofds_mul.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none
module ofds_mul
  import ofds_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [MUL_AW-1:0] op_a,
  input  wire logic signed [MUL_BW-1:0] op_b,
  output logic signed      [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  // Multiply and hold the product for the next step
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// ----- rtl/optical_flow_frame_decode_scale_top.sv -----
// Top level: frame decoder with height scaling and rotation compensation.
`default_nettype none
// A byte that does not complete a frame gives no result; the block stays ready for the
// next byte. A byte that completes a frame (FE 04 xa xb ya yb ck q AA, nine fresh bytes
// since reset or the last frame) starts an 8-step pass through one shared 34x17 signed
// multiplier: motion*height, times scale_gain, rate*rate_gain, then subtract, round half
// up by 2^16 and saturate, once for X and once for Y. The block is not ready until that
// pass ends and it has delivered the result into an output register; while an earlier
// result is still waiting there, it holds in its final step. Roll, pitch and height are
// taken from the request that carries the closing 0xAA byte. Gains are written over the
// APB port at byte offsets 0 (scale_gain) and 4 (rate_gain).
module optical_flow_frame_decode_scale_top
  import ofds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_X_MH, S_X_MG, S_X_RT, S_Y_MH, S_Y_MG, S_Y_RT, S_Y_SUB, S_DONE
  } state_t;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
  localparam int unsigned SHIFT_W = PROD_W - 16;

  state_t                   state_r;
  gains_t                   gains;
  frame_t                   frame;
  in_t                      req_r;
  out_t                     out_r;
  logic                     out_valid_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [31:0]       x_res_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_AW-1:0] op_a;
  logic signed [MUL_BW-1:0] op_b;
  logic                     mul_en;
  logic                     in_fire;
  logic                     out_fire;
  logic                     load_out;

  // Floor shift by 2^16, then clamp to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [SHIFT_W-1:0] q;
    q = SHIFT_W'(v >>> 16);
    if (q > SHIFT_W'(64'sd2147483647)) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (q < -SHIFT_W'(64'sd2147483648)) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = q[31:0];
    end
  endfunction

  ofds_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .gains       (gains)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid_r & out_ready;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  ofds_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (in_fire),
    .rx_byte  (in_data.rx_byte),
    .frame    (frame)
  );

  // Select multiplier operands for the current step
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    mul_en = 1'b1;
    case (state_r)
      S_X_MH: begin
        op_a = MUL_AW'(frame.mx);
        op_b = {1'b0, req_r.height};
      end
      S_X_MG, S_Y_MG: begin
        op_a = MUL_AW'($signed(prod[32:0]));
        op_b = {1'b0, gains.scale_gain};
      end
      S_X_RT: begin
        op_a = MUL_AW'(req_r.pitch_vel);
        op_b = {1'b0, gains.rate_gain};
      end
      S_Y_MH: begin
        op_a = MUL_AW'(frame.my);
        op_b = {1'b0, req_r.height};
      end
      S_Y_RT: begin
        op_a = MUL_AW'(req_r.roll_vel);
        op_b = {1'b0, gains.rate_gain};
      end
      default: mul_en = 1'b0;
    endcase
  end

  ofds_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Sequencer, accumulator and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_fire && !load_out) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            req_r <= in_data;
            if (frame.hit) begin
              state_r <= S_X_MH;
            end
          end
        end
        S_X_MH:  state_r <= S_X_MG;
        S_X_MG:  state_r <= S_X_RT;
        S_X_RT: begin
          acc_r   <= prod;
          state_r <= S_Y_MH;
        end
        S_Y_MH: begin
          acc_r   <= acc_r - prod + ROUND_HALF;
          state_r <= S_Y_MG;
        end
        S_Y_MG: begin
          x_res_r <= sat32(acc_r);
          state_r <= S_Y_RT;
        end
        S_Y_RT: begin
          acc_r   <= prod;
          state_r <= S_Y_SUB;
        end
        S_Y_SUB: begin
          acc_r   <= acc_r - prod + ROUND_HALF;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            out_r.x_flow  <= x_res_r;
            out_r.y_flow  <= sat32(acc_r);
            out_r.quality <= frame.quality;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A byte that completes no frame leaves the sequencer idle
  a_no_hit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !frame.hit |=> state_r == S_IDLE)
    else $error("sequencer started without a frame match");

  // A frame match blocks further input on the next cycle
  a_hit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && frame.hit |=> !in_ready)
    else $error("input accepted during frame computation");

  // A new result appears only from the final step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final step");

  // A result still waiting holds the sequencer in its final step
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && !out_ready |=> state_r == S_DONE)
    else $error("result overwritten before it was taken");

endmodule
`default_nettype wire
